FILE: rtl/assert_macros.svh
// Assertion macros for the meter's RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked assertion, switched off while reset is applied.
`define PWMM_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("pwmm assertion failed");
// Clocked assertion that also holds during reset.
`define PWMM_ASSERT_ALWAYS(lbl, ck, prop) \
	lbl: assert property (@(posedge ck) prop) \
		else $error("pwmm assertion failed");
`else
`define PWMM_ASSERT(lbl, ck, rn, prop)
`define PWMM_ASSERT_ALWAYS(lbl, ck, prop)
`endif
`endif

FILE: rtl/pwmm_pkg.sv
package pwmm_pkg;

	// Configuration port geometry.
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_TICK_RATE = 2'd0;
	localparam logic [1:0] REG_FREQ_MIN  = 2'd1;
	localparam logic [1:0] REG_FREQ_MAX  = 2'd2;
	localparam logic [1:0] REG_TIMEOUT   = 2'd3;

	// Register reset values.
	localparam logic [26:0] TICK_RATE_RST = 27'd1000000;
	localparam logic [15:0] FREQ_MIN_RST  = 16'd80;
	localparam logic [15:0] FREQ_MAX_RST  = 16'd550;
	localparam logic [23:0] TIMEOUT_RST   = 24'd500000;

	// Duty arithmetic.
	localparam logic [6:0] DUTY_MAX   = 7'd100;
	localparam logic [6:0] DUTY_SCALE = 7'd100;

	typedef struct packed {
		logic [26:0] tick_rate_hz;
		logic [15:0] freq_min_hz;
		logic [15:0] freq_max_hz;
		logic [23:0] timeout_ticks;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cap;
		logic edge_fall;
		logic edge_rise;
		logic start_freq;
		logic start_duty;
		logic store_meas;
		logic do_read;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic func;
		logic level;
		logic in_range;
		logic meas_ok;
		logic div_done;
		logic band_ok;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/pwmm_regs.sv
module pwmm_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pwmm_pkg::ADDR_W-1:0]  paddr,
	input  logic [pwmm_pkg::DATA_W-1:0]  pwdata,
	output logic [pwmm_pkg::DATA_W-1:0]  prdata,
	output pwmm_pkg::cfg_t               cfg
);

	logic       wr_en;
	logic [1:0] reg_idx;

	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	// Register writes on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.tick_rate_hz  <= pwmm_pkg::TICK_RATE_RST;
			cfg.freq_min_hz   <= pwmm_pkg::FREQ_MIN_RST;
			cfg.freq_max_hz   <= pwmm_pkg::FREQ_MAX_RST;
			cfg.timeout_ticks <= pwmm_pkg::TIMEOUT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				pwmm_pkg::REG_TICK_RATE: cfg.tick_rate_hz  <= pwdata[26:0];
				pwmm_pkg::REG_FREQ_MIN:  cfg.freq_min_hz   <= pwdata[15:0];
				pwmm_pkg::REG_FREQ_MAX:  cfg.freq_max_hz   <= pwdata[15:0];
				pwmm_pkg::REG_TIMEOUT:   cfg.timeout_ticks <= pwdata[23:0];
				default: begin
				end
			endcase
		end
	end

	// Read-back of the addressed register.
	always_comb begin
		case (reg_idx)
			pwmm_pkg::REG_TICK_RATE: prdata = 32'(cfg.tick_rate_hz);
			pwmm_pkg::REG_FREQ_MIN:  prdata = 32'(cfg.freq_min_hz);
			pwmm_pkg::REG_FREQ_MAX:  prdata = 32'(cfg.freq_max_hz);
			pwmm_pkg::REG_TIMEOUT:   prdata = 32'(cfg.timeout_ticks);
			default:                 prdata = '0;
		endcase
	end

endmodule

FILE: rtl/pwmm_div.sv
module pwmm_div #(
	parameter int N = 31,
	parameter int D = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [D-1:0] divisor,
	output logic         busy,
	output logic         done,
	output logic [N-1:0] quotient
);

	localparam int CNT_W = $clog2(N);

	logic [D-1:0]     rem_q;
	logic [N-1:0]     quo_q;
	logic [D-1:0]     dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D:0]       shifted;
	logic [D+1:0]     diff;
	logic             ge;

	// One restoring step: bring down a dividend bit and try a subtraction.
	assign shifted = {rem_q, quo_q[N-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge      = ~diff[D+1];

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	// Remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[D-1:0] : shifted[D-1:0];
			quo_q <= {quo_q[N-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/pwmm_datapath.sv
`include "assert_macros.svh"

module pwmm_datapath #(
	parameter int CHANNELS  = 2,
	parameter int TICK_BITS = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pwmm_pkg::cfg_t  cfg,
	input  pwmm_pkg::cmd_t  cmd,
	output pwmm_pkg::sts_t  sts,
	input  logic            func,
	input  logic            channel,
	input  logic            level,
	input  logic [23:0]     now_tick,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            ready_res,
	output logic [15:0]     freq_hz,
	output logic [6:0]      duty_pct
);

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DIV_N = (TICK_BITS + 7 > 27) ? TICK_BITS + 7 : 27;
	localparam int EXT_W = TICK_BITS + 24;
	localparam int MUL_W = TICK_BITS + 7;

	// Captured request.
	logic                 func_q;
	logic                 level_q;
	logic                 ch_q;
	logic [TICK_BITS-1:0] now_q;
	logic [TICK_BITS-1:0] period_q;
	logic [15:0]          freq_q;

	// Per-channel measurement state.
	logic [TICK_BITS-1:0] last_rise_q [CHANNELS];
	logic [TICK_BITS-1:0] last_edge_q [CHANNELS];
	logic [TICK_BITS-1:0] high_time_q [CHANNELS];
	logic [15:0]          st_freq_q   [CHANNELS];
	logic [6:0]           st_duty_q   [CHANNELS];
	logic [CHANNELS-1:0]  rise_seen_q;
	logic [CHANNELS-1:0]  high_valid_q;
	logic [CHANNELS-1:0]  data_ready_q;
	logic [CHANNELS-1:0]  present_q;

	// Output register.
	logic                 out_valid_q;
	logic                 out_ready_res_q;
	logic [15:0]          out_freq_q;
	logic [6:0]           out_duty_q;

	logic [CH_W-1:0]      ch_idx;
	logic                 in_range;
	logic [TICK_BITS-1:0] since_rise;
	logic [TICK_BITS-1:0] since_edge;
	logic                 timeout_hit;
	logic [MUL_W-1:0]     high_x100;
	logic [DIV_N-1:0]     duty_num;
	logic                 div_start;
	logic [DIV_N-1:0]     div_dividend;
	logic [TICK_BITS-1:0] div_divisor;
	logic                 div_busy;
	logic                 div_done;
	logic [DIV_N-1:0]     quo;
	logic [6:0]           duty_cap;

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			func_q  <= func;
			level_q <= level;
			ch_q    <= channel;
			now_q   <= TICK_BITS'(now_tick);
		end
	end

	// Channel selection and elapsed times.
	assign ch_idx     = CH_W'(ch_q);
	assign in_range   = 32'(ch_q) < 32'(CHANNELS);
	assign since_rise = now_q - last_rise_q[ch_idx];
	assign since_edge = now_q - last_edge_q[ch_idx];
	assign timeout_hit = present_q[ch_idx] &&
		(EXT_W'(since_edge) >= EXT_W'(cfg.timeout_ticks));

	// Divider operands: frequency first, then duty.
	assign high_x100    = MUL_W'(high_time_q[ch_idx]) * MUL_W'(pwmm_pkg::DUTY_SCALE);
	assign duty_num     = DIV_N'(high_x100) + DIV_N'(period_q >> 1);
	assign div_start    = cmd.start_freq | cmd.start_duty;
	assign div_dividend = cmd.start_duty ? duty_num : DIV_N'(cfg.tick_rate_hz);
	assign div_divisor  = cmd.start_duty ? period_q : since_rise;

	pwmm_div #(
		.N (DIV_N),
		.D (TICK_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	assign duty_cap = (quo > DIV_N'(pwmm_pkg::DUTY_MAX)) ? pwmm_pkg::DUTY_MAX : quo[6:0];

	// Period and accepted frequency held between the two divisions.
	always_ff @(posedge clk) begin
		if (cmd.start_freq) begin
			period_q <= since_rise;
		end
		if (cmd.start_duty) begin
			freq_q <= quo[15:0];
		end
	end

	// Per-channel state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				last_rise_q[i] <= '0;
				last_edge_q[i] <= '0;
				high_time_q[i] <= '0;
				st_freq_q[i]   <= '0;
				st_duty_q[i]   <= '0;
			end
			rise_seen_q  <= '0;
			high_valid_q <= '0;
			data_ready_q <= '0;
			present_q    <= '0;
		end else begin
			if (cmd.edge_fall) begin
				last_edge_q[ch_idx] <= now_q;
				if (rise_seen_q[ch_idx]) begin
					high_time_q[ch_idx]  <= since_rise;
					high_valid_q[ch_idx] <= 1'b1;
				end
			end
			if (cmd.edge_rise) begin
				last_edge_q[ch_idx]  <= now_q;
				last_rise_q[ch_idx]  <= now_q;
				rise_seen_q[ch_idx]  <= 1'b1;
				high_valid_q[ch_idx] <= 1'b0;
				if (cmd.store_meas) begin
					st_freq_q[ch_idx]    <= freq_q;
					st_duty_q[ch_idx]    <= duty_cap;
					data_ready_q[ch_idx] <= 1'b1;
					present_q[ch_idx]    <= 1'b1;
				end
			end
			if (cmd.do_read && in_range) begin
				data_ready_q[ch_idx] <= 1'b0;
				if (timeout_hit) begin
					high_time_q[ch_idx]  <= '0;
					st_freq_q[ch_idx]    <= '0;
					st_duty_q[ch_idx]    <= '0;
					rise_seen_q[ch_idx]  <= 1'b0;
					high_valid_q[ch_idx] <= 1'b0;
					present_q[ch_idx]    <= 1'b0;
				end
			end
		end
	end

	// Result register; a new result may load as the old one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.do_read) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_read) begin
			if (!in_range || timeout_hit) begin
				out_ready_res_q <= in_range;
				out_freq_q      <= '0;
				out_duty_q      <= '0;
			end else begin
				out_ready_res_q <= data_ready_q[ch_idx];
				out_freq_q      <= st_freq_q[ch_idx];
				out_duty_q      <= st_duty_q[ch_idx];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign ready_res = out_ready_res_q;
	assign freq_hz   = out_freq_q;
	assign duty_pct  = out_duty_q;

	// Status to the controller.
	assign sts.func     = func_q;
	assign sts.level    = level_q;
	assign sts.in_range = in_range;
	assign sts.meas_ok  = rise_seen_q[ch_idx] && high_valid_q[ch_idx] &&
		(since_rise != '0) && (high_time_q[ch_idx] <= since_rise);
	assign sts.div_done = div_done;
	assign sts.band_ok  = (quo >= DIV_N'(cfg.freq_min_hz)) && (quo <= DIV_N'(cfg.freq_max_hz));
	assign sts.out_free = ~out_valid_q | out_ready;

	`PWMM_ASSERT(a_div_idle_at_start, clk, arst_n, div_start |-> !div_busy)
	`PWMM_ASSERT(a_result_from_read, clk, arst_n, $rose(out_valid_q) |-> $past(cmd.do_read))
	`PWMM_ASSERT(a_duty_in_range, clk, arst_n, out_valid_q |-> (out_duty_q <= pwmm_pkg::DUTY_MAX))
	`PWMM_ASSERT_ALWAYS(a_no_result_in_reset, clk, !arst_n |-> !out_valid_q)

endmodule

FILE: rtl/pwmm_ctrl.sv
module pwmm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  pwmm_pkg::sts_t sts,
	output pwmm_pkg::cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_WAIT_F = 6'b000100,
		S_CHECK  = 6'b001000,
		S_WAIT_D = 6'b010000,
		S_READ   = 6'b100000
	} state_t;

	state_t st_q;
	state_t st_next;

	// Sequencing of one request at a time.
	always_comb begin
		st_next = st_q;
		cmd     = '0;
		case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					st_next = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.func) begin
					st_next = S_READ;
				end else if (!sts.in_range) begin
					st_next = S_IDLE;
				end else if (!sts.level) begin
					cmd.edge_fall = 1'b1;
					st_next       = S_IDLE;
				end else if (sts.meas_ok) begin
					cmd.start_freq = 1'b1;
					st_next        = S_WAIT_F;
				end else begin
					cmd.edge_rise = 1'b1;
					st_next       = S_IDLE;
				end
			end
			S_WAIT_F: begin
				if (sts.div_done) begin
					st_next = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.band_ok) begin
					cmd.start_duty = 1'b1;
					st_next        = S_WAIT_D;
				end else begin
					cmd.edge_rise = 1'b1;
					st_next       = S_IDLE;
				end
			end
			S_WAIT_D: begin
				if (sts.div_done) begin
					cmd.store_meas = 1'b1;
					cmd.edge_rise  = 1'b1;
					st_next        = S_IDLE;
				end
			end
			S_READ: begin
				if (sts.out_free) begin
					cmd.do_read = 1'b1;
					st_next     = S_IDLE;
				end
			end
			default: begin
				st_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			st_q <= st_next;
		end
	end

	assign in_ready = (st_q == S_IDLE);

endmodule

FILE: rtl/pwm_input_freq_duty_meter_unit.sv
// PWM input frequency and duty meter.
// Requests arrive on the in channel (in_valid/in_ready) as func, channel,
// level and now_tick. An edge request (func 0) records a pin edge; a rising
// edge that closes a full period starts a frequency division on one shared
// restoring divider and, when the frequency lies in the configured band, a
// duty division after it, then stores both. A read request (func 1) applies
// the no-edge timeout and gives one result on the out channel (ready_res,
// freq_hz, duty_pct). One request is worked at a time. An edge request is
// captured and decoded; when a period is measured, the controller waits on
// the divider, which gives one quotient bit per cycle. A read request is
// captured, decoded and loaded into the result register once it is free.
// The result register lets the next request be accepted while a result waits;
// if the receiver stalls, a later read waits until the held result is taken.
// Reset clears all channel state, loads the register defaults and empties the
// result register. Registers sit on the APB port at 4-byte steps.
module pwm_input_freq_duty_meter_unit #(
	parameter int CHANNELS  = 2,
	parameter int TICK_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pwmm_pkg::ADDR_W-1:0]  paddr,
	input  logic [pwmm_pkg::DATA_W-1:0]  pwdata,
	output logic [pwmm_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         func,
	input  logic                         channel,
	input  logic                         level,
	input  logic [23:0]                  now_tick,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         ready_res,
	output logic [15:0]                  freq_hz,
	output logic [6:0]                   duty_pct
);

	pwmm_pkg::cfg_t cfg;
	pwmm_pkg::cmd_t cmd;
	pwmm_pkg::sts_t sts;

	assign pready = 1'b1;

	// Configuration registers.
	pwmm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Sequencer.
	pwmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Channel state, divider and result register.
	pwmm_datapath #(
		.CHANNELS  (CHANNELS),
		.TICK_BITS (TICK_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.func      (func),
		.channel   (channel),
		.level     (level),
		.now_tick  (now_tick),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ready_res (ready_res),
		.freq_hz   (freq_hz),
		.duty_pct  (duty_pct)
	);

endmodule
